// ----- hw/rtl/cfe_pkg.sv -----
// shared types, constants and tap decode for the centered zero-padded fir
package cfe_pkg;

    localparam int MAX_TAPS       = 7;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int OUT_BITS       = 34;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int TAP_W          = 3;
    localparam int HIST_DEPTH     = MAX_TAPS - 1;
    localparam int DLY_W          = $clog2(MAX_TAPS / 2 + 1);
    localparam int IDX_W          = $clog2(MAX_TAPS);
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int S_TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int NUM_PARTS      = (MAX_TAPS + 1) / 2;

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAP_COUNT,
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5,
        REG_COEF_6
    } cfg_reg_t;

    typedef logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] window_t;
    typedef logic [MAX_TAPS-1:0][COEF_BITS-1:0]   coef_bank_t;

    typedef struct packed {
        logic [TAP_W-1:0] nt;
        logic [DLY_W-1:0] cen;
        logic [DLY_W-1:0] dly;
    } tap_info_t;

    typedef struct packed {
        window_t          win;
        logic [DLY_W-1:0] d_start;
        logic             last;
    } job_t;

    function automatic tap_info_t tap_decode(input logic [TAP_W-1:0] tap_count);
        tap_info_t info;
        logic [TAP_W-1:0] half;
        info.nt  = (tap_count == '0) ? TAP_W'(1) : tap_count;
        half     = info.nt >> 1;
        info.cen = DLY_W'(half);
        info.dly = DLY_W'(info.nt - TAP_W'(1) - half);
        return info;
    endfunction

endpackage

// ----- hw/rtl/centered_fir_zero_padded_core.sv -----
// top level: configuration registers, front end, job queue and back end
//
// Centered zero-padded FIR over blocks of 16-bit signed samples with Q1.14
// coefficients, giving one exact 34-bit result per sample. A sample word that
// is not the last of its block queues a one-result job once D earlier samples
// of the block were taken; the last word queues a job of min(samples so far,
// D) + 1 results, where D = taps - 1 - taps/2. The back end issues one result
// per cycle while m_tready allows, so the input stalls once the job queue of
// QUEUE_DEPTH entries is full. The single result issue slot of the back end
// sets the sustained rate. Configuration is written through cfg_we, cfg_index
// and cfg_data, by the user only while the block is idle; the block does not check.
module centered_fir_zero_padded_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfe_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    input  logic                              s_tlast,   // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfe_pkg::M_TDATA_W-1:0]     m_tdata,   // [33:0] filtered
    output logic                              m_tlast,   // out_last
    input  logic                              cfg_we,
    input  logic [cfe_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [cfe_pkg::TAP_W-1:0] tap_count_reg;
    cfe_pkg::coef_bank_t       coef_reg;
    logic                      q_push, q_pop, q_full, q_valid;
    cfe_pkg::job_t             push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= cfe_pkg::TAP_W'(1);
            coef_reg      <= {{(cfe_pkg::MAX_TAPS-1){cfe_pkg::COEF_BITS'(0)}},
                              cfe_pkg::COEF_ONE};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfe_pkg::REG_TAP_COUNT:
                begin
                    tap_count_reg <= cfg_data[cfe_pkg::TAP_W-1:0];
                end
                default:
                begin
                    coef_reg[cfe_pkg::IDX_W'(cfg_index - cfe_pkg::REG_IDX_W'(1))]
                        <= cfg_data[cfe_pkg::COEF_BITS-1:0];
                end
            endcase
        end
    end

    cfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .tap_count (tap_count_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    cfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    cfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_count (tap_count_reg),
        .coef      (coef_reg),
        .q_valid   (q_valid),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hw/rtl/cfe_front.sv -----
// front end: takes sample words, keeps the block history, queues result jobs
module cfe_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cfe_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample
    input  logic                             s_tlast,   // block_end
    input  logic [cfe_pkg::TAP_W-1:0]        tap_count,
    input  logic                             q_full,
    output logic                             q_push,
    output cfe_pkg::job_t                    q_job
);

    logic [cfe_pkg::HIST_DEPTH-1:0][cfe_pkg::SAMPLE_BITS-1:0] hist_reg, hist_next;
    logic [cfe_pkg::TAP_W-1:0] seen_reg, seen_next;
    cfe_pkg::tap_info_t        info;
    logic                      accept;
    logic                      short_run;
    logic [cfe_pkg::SAMPLE_BITS-1:0] sample;

    always_comb
    begin
        info      = cfe_pkg::tap_decode(tap_count);
        sample    = s_tdata[cfe_pkg::SAMPLE_BITS-1:0];
        s_tready  = !q_full;
        accept    = s_tvalid && !q_full;
        short_run = seen_reg < cfe_pkg::TAP_W'(info.dly);

        q_job.win[0] = sample;
        for (int k = 1; k < cfe_pkg::MAX_TAPS; k++)
        begin
            q_job.win[k] = hist_reg[k-1];
        end
        q_job.last = s_tlast;
        if (s_tlast && short_run)
        begin
            q_job.d_start = cfe_pkg::DLY_W'(seen_reg);
        end
        else
        begin
            q_job.d_start = info.dly;
        end
        q_push = accept && (s_tlast || !short_run);
    end

    always_comb
    begin
        hist_next = hist_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                hist_next = '0;
                seen_next = '0;
            end
            else
            begin
                hist_next[0] = sample;
                for (int k = 1; k < cfe_pkg::HIST_DEPTH; k++)
                begin
                    hist_next[k] = hist_reg[k-1];
                end
                if (seen_reg != '1)
                begin
                    seen_next = seen_reg + cfe_pkg::TAP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ----- hw/rtl/cfe_queue.sv -----
// job queue between front end and back end
module cfe_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfe_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output cfe_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfe_pkg::job_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        full        = count_reg == CNT_W'(DEPTH);
        valid       = count_reg != '0;
        head_job    = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");
`endif

endmodule

// ----- hw/rtl/cfe_back.sv -----
// back end: walks each job's results through a multiply and add-tree pipeline
module cfe_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cfe_pkg::TAP_W-1:0]     tap_count,
    input  cfe_pkg::coef_bank_t           coef,
    input  logic                          q_valid,
    input  cfe_pkg::job_t                 q_job,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cfe_pkg::M_TDATA_W-1:0] m_tdata,   // [33:0] filtered
    output logic                          m_tlast    // out_last
);

    cfe_pkg::tap_info_t           info;
    logic                         cur_valid_reg, cur_valid_next;
    cfe_pkg::job_t                cur_job_reg, cur_job_next;
    logic [cfe_pkg::DLY_W-1:0]    cur_d_reg, cur_d_next;
    logic                         advance;
    logic                         issue;
    logic                         final_issue;
    logic                         issue_last;
    logic [cfe_pkg::TAP_W-1:0]    sel;
    logic [cfe_pkg::MAX_TAPS-1:0][cfe_pkg::SAMPLE_BITS-1:0] opnd;

    logic                         p1_valid_reg, p1_last_reg;
    logic signed [cfe_pkg::PROD_BITS-1:0] p1_prod_reg [cfe_pkg::MAX_TAPS];
    logic                         s2_valid_reg, s2_last_reg;
    logic signed [cfe_pkg::OUT_BITS-1:0]  s2_part_reg [cfe_pkg::NUM_PARTS];
    logic signed [cfe_pkg::OUT_BITS-1:0]  part_next [cfe_pkg::NUM_PARTS];
    logic signed [cfe_pkg::OUT_BITS-1:0]  sum_next;
    logic                         out_valid_reg, out_last_reg;
    logic [cfe_pkg::OUT_BITS-1:0] out_data_reg;

    // job walk
    always_comb
    begin
        info        = cfe_pkg::tap_decode(tap_count);
        advance     = !out_valid_reg || m_tready;
        issue       = cur_valid_reg && advance;
        issue_last  = cur_job_reg.last && (cur_d_reg == '0);
        final_issue = issue && (!cur_job_reg.last || cur_d_reg == '0);
        q_pop       = q_valid && (!cur_valid_reg || final_issue);

        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        cur_d_next     = cur_d_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_job_next   = q_job;
            cur_d_next     = q_job.d_start;
        end
        else if (final_issue)
        begin
            cur_valid_next = 1'b0;
        end
        else if (issue)
        begin
            cur_d_next = cur_d_reg - cfe_pkg::DLY_W'(1);
        end
    end

    // tap operand select: tap j reads the sample of age d + cen - j
    always_comb
    begin
        sel = cfe_pkg::TAP_W'(cur_d_reg) + cfe_pkg::TAP_W'(info.cen);
        for (int j = 0; j < cfe_pkg::MAX_TAPS; j++)
        begin
            if (cfe_pkg::TAP_W'(j) < info.nt && sel >= cfe_pkg::TAP_W'(j))
            begin
                opnd[j] = cur_job_reg.win[cfe_pkg::IDX_W'(sel - cfe_pkg::TAP_W'(j))];
            end
            else
            begin
                opnd[j] = '0;
            end
        end
    end

    // pairwise partial sums and final sum
    always_comb
    begin
        for (int k = 0; k < cfe_pkg::NUM_PARTS; k++)
        begin
            if (2 * k + 1 < cfe_pkg::MAX_TAPS)
            begin
                part_next[k] = cfe_pkg::OUT_BITS'(p1_prod_reg[2*k])
                             + cfe_pkg::OUT_BITS'(p1_prod_reg[2*k+1]);
            end
            else
            begin
                part_next[k] = cfe_pkg::OUT_BITS'(p1_prod_reg[2*k]);
            end
        end
        sum_next = '0;
        for (int k = 0; k < cfe_pkg::NUM_PARTS; k++)
        begin
            sum_next = sum_next + s2_part_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            if (advance)
            begin
                p1_valid_reg  <= issue;
                s2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        cur_d_reg   <= cur_d_next;
        if (advance)
        begin
            p1_last_reg <= issue_last;
            for (int j = 0; j < cfe_pkg::MAX_TAPS; j++)
            begin
                p1_prod_reg[j] <= cfe_pkg::PROD_BITS'($signed(coef[j]))
                                * cfe_pkg::PROD_BITS'($signed(opnd[j]));
            end
            s2_last_reg  <= p1_last_reg;
            s2_part_reg  <= part_next;
            out_last_reg <= s2_last_reg;
            out_data_reg <= sum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(cfe_pkg::M_TDATA_W - cfe_pkg::OUT_BITS){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    a_issue_enters: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> p1_valid_reg)
        else $error("issued word did not enter the multiply stage");

    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && p1_last_reg && advance) |=> (s2_valid_reg && s2_last_reg))
        else $error("last flag lost between stages");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_d_reg <= info.dly))
        else $error("job offset beyond the tap delay");
`endif

endmodule
